@@ design/rgbct_pkg.sv @@
`default_nettype none

package rgbct_pkg;

    localparam int COLOUR_W = 32;
    localparam int KELVIN_W = 14;
    localparam int CHAN_W   = 8;
    localparam int FACTOR_W = 16;
    localparam int SLOPE_W  = 7;
    localparam int SUM_W    = 16;

    localparam logic [SUM_W-1:0] KELVIN_EQUAL = SUM_W'(6550);
    localparam logic [SUM_W-1:0] KELVIN_MAX   = SUM_W'(10091);

    // which channel dominates
    typedef enum logic [1:0] {
        MODE_EQUAL = 2'd0,
        MODE_RED   = 2'd1,
        MODE_BLUE  = 2'd2
    } mode_t;

    // one linear segment: kelvin = base + diff * slope, clamped if asked
    typedef struct packed {
        logic [SUM_W-1:0]   base;
        logic [CHAN_W-1:0]  diff;
        logic [SLOPE_W-1:0] slope;
        logic               clamp;
    } seg_t;

endpackage

`default_nettype wire

@@ design/rgbct_stream_if.sv @@
`default_nettype none

interface rgbct_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] packed_colour;

    modport source (output valid, output packed_colour, input ready);
    modport sink   (input valid, input packed_colour, output ready);
endinterface

interface rgbct_out_if;
    logic        valid;
    logic        ready;
    logic [13:0] kelvin;

    modport source (output valid, output kelvin, input ready);
    modport sink   (input valid, input kelvin, output ready);
endinterface

`default_nettype wire

@@ design/rgbct_segment.sv @@
`default_nettype none

module rgbct_segment (
    input  wire logic [rgbct_pkg::CHAN_W-1:0] scaled,
    input  wire rgbct_pkg::mode_t             mode,
    output rgbct_pkg::seg_t                   seg
);
    import rgbct_pkg::*;

    function automatic seg_t make_seg(input logic [SUM_W-1:0] base,
                                      input logic [CHAN_W-1:0] diff,
                                      input logic [SLOPE_W-1:0] slope,
                                      input logic clamp);
        seg_t s;
        s.base  = base;
        s.diff  = diff;
        s.slope = slope;
        s.clamp = clamp;
        return s;
    endfunction

    logic [CHAN_W-1:0] v;

    assign v = scaled;

    always_comb
    begin
        seg = make_seg(KELVIN_EQUAL, '0, '0, 1'b0);
        unique case (mode)
            MODE_RED:
            begin
                // scaled blue through nine segments
                priority if (v < 8'd33)  seg = make_seg(16'd1900, v,          7'd6,  1'b0);
                else if (v < 8'd72)      seg = make_seg(16'd2100, v - 8'd33,  7'd10, 1'b0);
                else if (v < 8'd101)     seg = make_seg(16'd2492, v - 8'd72,  7'd14, 1'b0);
                else if (v < 8'd132)     seg = make_seg(16'd2900, v - 8'd101, 7'd16, 1'b0);
                else if (v < 8'd159)     seg = make_seg(16'd3398, v - 8'd132, 7'd19, 1'b0);
                else if (v < 8'd186)     seg = make_seg(16'd3906, v - 8'd159, 7'd22, 1'b0);
                else if (v < 8'd210)     seg = make_seg(16'd4500, v - 8'd186, 7'd25, 1'b0);
                else if (v < 8'd230)     seg = make_seg(16'd5100, v - 8'd210, 7'd30, 1'b0);
                else                     seg = make_seg(16'd5700, v - 8'd230, 7'd34, 1'b0);
            end
            MODE_BLUE:
            begin
                // scaled red through two segments, the lower one clamped
                priority if (v == 8'd255) seg = make_seg(16'd6600, 8'd0,       7'd50, 1'b0);
                else if (v > 8'd225)      seg = make_seg(16'd6600, 8'd254 - v, 7'd50, 1'b0);
                else                      seg = make_seg(16'd8080, 8'd225 - v, 7'd86, 1'b1);
            end
            MODE_EQUAL:
            begin
                seg = make_seg(KELVIN_EQUAL, '0, '0, 1'b0);
            end
            default:
            begin
                seg = make_seg(KELVIN_EQUAL, '0, '0, 1'b0);
            end
        endcase
    end

endmodule

`default_nettype wire

@@ design/rgb_to_colour_temperature.sv @@
// Colour temperature estimate from a packed colour word. Red (23:16) and blue
// (7:0) set the result; white and green are ignored. The block is a four-stage
// pipeline: one transaction is accepted every clock while the output is not
// stalled. Stage one picks the stronger channel and looks up 65535 divided by
// it in a 256-entry constant table, stage two multiplies the weaker channel by
// that factor, stage three selects the linear segment, and stage four
// evaluates and clamps it. When the result is held by the sink the whole
// pipeline stalls and the input is not ready.
`default_nettype none

module rgb_to_colour_temperature (
    input  wire logic   clk,
    input  wire logic   rst_n,
    rgbct_in_if.sink    pixel,
    rgbct_out_if.source result
);
    import rgbct_pkg::*;

    // 65535 / stronger channel, built at elaboration
    logic [FACTOR_W-1:0] factor_rom [256];

    for (genvar g = 0; g < 256; g++)
    begin : g_rom
        localparam int Div = (g == 0) ? 1 : g;
        localparam logic [FACTOR_W-1:0] Factor = FACTOR_W'(32'hFFFF / Div);
        assign factor_rom[g] = Factor;
    end

    logic advance;

    logic v1_reg, v2_reg, v3_reg, v4_reg;

    logic [CHAN_W-1:0]   weak_reg, weak_next;
    logic [FACTOR_W-1:0] factor_reg, factor_next;
    mode_t               mode1_reg, mode1_next;

    logic [CHAN_W-1:0]   scaled_reg, scaled_next;
    mode_t               mode2_reg;

    seg_t                seg_reg, seg_next;

    logic [KELVIN_W-1:0] kelvin_reg, kelvin_next;

    logic [CHAN_W-1:0]   red, blue, lead;
    logic [23:0]         product;
    logic [14:0]         slope_prod;
    logic [SUM_W-1:0]    sum;

    // advance when the output slot is empty or being drained
    assign advance     = !v4_reg || result.ready;
    assign pixel.ready = advance;

    // stage 1: compare and look up the factor
    assign red  = pixel.packed_colour[23:16];
    assign blue = pixel.packed_colour[7:0];

    always_comb
    begin
        priority if (red == blue)
        begin
            mode1_next = MODE_EQUAL;
            weak_next  = blue;
            lead       = red;
        end
        else if (red > blue)
        begin
            mode1_next = MODE_RED;
            weak_next  = blue;
            lead       = red;
        end
        else
        begin
            mode1_next = MODE_BLUE;
            weak_next  = red;
            lead       = blue;
        end
        factor_next = factor_rom[lead];
    end

    // stage 2: scale the weaker channel
    assign product     = 24'(weak_reg) * 24'(factor_reg);
    assign scaled_next = product[15:8];

    // stage 3: segment selection
    rgbct_segment u_segment (
        .scaled (scaled_reg),
        .mode   (mode2_reg),
        .seg    (seg_next)
    );

    // stage 4: evaluate and clamp
    assign slope_prod = 15'(seg_reg.diff) * 15'(seg_reg.slope);
    assign sum        = seg_reg.base + SUM_W'(slope_prod);

    always_comb
    begin
        if (seg_reg.clamp && (sum > KELVIN_MAX))
        begin
            kelvin_next = KELVIN_W'(KELVIN_MAX);
        end
        else
        begin
            kelvin_next = sum[KELVIN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= pixel.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            weak_reg   <= weak_next;
            factor_reg <= factor_next;
            mode1_reg  <= mode1_next;
            scaled_reg <= scaled_next;
            mode2_reg  <= mode1_reg;
            seg_reg    <= seg_next;
            kelvin_reg <= kelvin_next;
        end
    end

    assign result.valid  = v4_reg;
    assign result.kelvin = kelvin_reg;

endmodule

`default_nettype wire

@@ design/rgbct_checker.sv @@
`default_nettype none

module rgbct_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        pixel_valid,
    input wire logic        pixel_ready,
    input wire logic [31:0] packed_colour,
    input wire logic        result_valid,
    input wire logic        result_ready,
    input wire logic [13:0] kelvin
);

    // a shown result stays in range
    a_kelvin_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (kelvin >= 14'd1900) && (kelvin <= 14'd10091))
        else $error("kelvin out of range");

    // a held result does not change
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(kelvin))
        else $error("held result changed");

    // an empty output slot never blocks the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> pixel_ready)
        else $error("input blocked with empty output");

    // a held result stalls the input
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |-> !pixel_ready)
        else $error("input accepted during output stall");

    // equal channels give 6550 at the output when nothing stalls
    a_equal: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && pixel_ready && (packed_colour[23:16] == packed_colour[7:0])
        && result_ready ##1 result_ready ##1 result_ready ##1 result_ready
        |=> result_valid && (kelvin == 14'd6550))
        else $error("equal channels not 6550");

endmodule

bind rgb_to_colour_temperature rgbct_checker u_rgbct_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .pixel_valid   (pixel.valid),
    .pixel_ready   (pixel.ready),
    .packed_colour (pixel.packed_colour),
    .result_valid  (result.valid),
    .result_ready  (result.ready),
    .kelvin        (result.kelvin)
);

`default_nettype wire
